[rtl/core/ccd_pkg.sv]
`timescale 1ns / 1ps

package ccd_pkg;

   // Default geometry
   localparam int MAX_COLUMNS_DEF = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int MASK_W     = 64;
   localparam int COUNT_W    = 7;
   localparam int TOL_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLUMNS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ABORT_FLOOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_APPROX_MODE  = 2'd3;

   // Verdict codes
   localparam logic VERDICT_ABORT = 1'b0;
   localparam logic VERDICT_DONE  = 1'b1;

   // Result queue depth
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic                verdict;
      logic [MASK_W-1:0]   mask;
      logic [COUNT_W-1:0]  count;
   } result_type;

endpackage

[rtl/core/constant_column_detector_unit.sv]
`timescale 1ns / 1ps

// Constant column detector. Matrix elements arrive row-major, one beat per element, and the
// block sustains one element per clock cycle while req_stall is low. Each element passes
// through the accept stage (its column's first-row entry is read from, or written to, the
// single-port first-row memory) and then a compare and count stage. Results wait in a
// four-deep queue; req_stall rises only when that queue plus the element in the compare
// stage would fill it, i.e. after results have been held back by rsp_stall. Configuration
// writes are always taken (csr_ready is tied high) and must only be made while idle.
module constant_column_detector_unit #(
   parameter int MAX_COLUMNS = ccd_pkg::MAX_COLUMNS_DEF,
   parameter int VALUE_WIDTH = ccd_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // element channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   input  logic                                req_last_element,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_verdict,
   output logic [ccd_pkg::MASK_W-1:0]          rsp_variable_mask,
   output logic [ccd_pkg::COUNT_W-1:0]         rsp_constant_count,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ccd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ccd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ccd_pkg::*;

   localparam int POS_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CMP_W   = (VALUE_WIDTH > TOL_W) ? VALUE_WIDTH : TOL_W;
   localparam int QPTR_W  = $clog2(FIFO_DEPTH);
   localparam int QCNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_COLUMNS);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [COUNT_W-1:0] num_columns_ff;
   logic [COUNT_W-1:0] abort_floor_ff;
   logic [TOL_W-1:0]   tolerance_ff;
   logic               approx_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff  <= COUNT_W'(64);
         abort_floor_ff  <= '0;
         tolerance_ff    <= '0;
         approx_mode_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NUM_COLUMNS:  num_columns_ff  <= csr_data[COUNT_W-1:0];
            REG_ABORT_FLOOR:  abort_floor_ff  <= csr_data[COUNT_W-1:0];
            REG_TOLERANCE:    tolerance_ff    <= csr_data[TOL_W-1:0];
            REG_APPROX_MODE:  approx_mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective column count, clamped to 1..MAX_COLUMNS
   logic [COUNT_W-1:0] eff_cols;
   always_comb begin
      if (num_columns_ff == '0)
         eff_cols = COUNT_W'(1);
      else if (num_columns_ff > MAX_CNT)
         eff_cols = MAX_CNT;
      else
         eff_cols = num_columns_ff;
   end

   // ------------------------------------------------------------------
   // Stage 0: column tracking and first-row memory access
   // ------------------------------------------------------------------
   logic [POS_W-1:0]   column_pos_ff, column_pos_in;
   logic               in_first_ff, in_first_in;
   logic [POS_W-1:0]   cur_pos;
   logic [COUNT_W-1:0] pos_next;
   logic               accept;
   logic [QCNT_W-1:0]  q_count_ff, q_count_in;
   logic               s1_valid_ff;
   logic [QCNT_W-1:0]  occupancy;

   assign occupancy = q_count_ff + QCNT_W'(s1_valid_ff);
   assign req_stall = (occupancy >= QCNT_W'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   // position wraps at the current column count
   always_comb begin
      if (COUNT_W'(column_pos_ff) >= eff_cols)
         cur_pos = '0;
      else
         cur_pos = column_pos_ff;
      pos_next = COUNT_W'(cur_pos) + COUNT_W'(1);
      if (req_last_element) begin
         column_pos_in = '0;
         in_first_in   = 1'b1;
      end else if (pos_next >= eff_cols) begin
         column_pos_in = '0;
         in_first_in   = 1'b0;
      end else begin
         column_pos_in = pos_next[POS_W-1:0];
         in_first_in   = in_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         in_first_ff   <= 1'b1;
      end else if (accept) begin
         column_pos_ff <= column_pos_in;
         in_first_ff   <= in_first_in;
      end
   end

   // first-row memory: one access per element, read data registered
   logic [VALUE_WIDTH-1:0] first_row_mem [MAX_COLUMNS];
   logic [VALUE_WIDTH-1:0] ref_data_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (in_first_ff)
            first_row_mem[cur_pos] <= req_value;
         ref_data_ff <= first_row_mem[cur_pos];
      end
   end

   // element carried into the compare stage
   logic [POS_W-1:0]       s1_pos_ff;
   logic                   s1_first_ff;
   logic                   s1_start_ff;
   logic                   s1_last_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff   <= cur_pos;
         s1_first_ff <= in_first_ff;
         s1_start_ff <= in_first_ff && (column_pos_ff == '0);
         s1_last_ff  <= req_last_element;
         s1_value_ff <= req_value;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: compare against the first row, update flags and count
   // ------------------------------------------------------------------
   logic [MAX_COLUMNS-1:0] flags_ff, flags_in;
   logic [COUNT_W-1:0]     left_ff, left_in;
   logic                   stopped_ff, stopped_in;

   logic signed [VALUE_WIDTH:0] diff;
   logic [VALUE_WIDTH:0]        diff_abs;
   logic [CMP_W-1:0]            mag;
   logic                        varies;
   logic [MAX_COLUMNS-1:0]      flags_base, flags_upd, col_bit;
   logic [COUNT_W-1:0]          left_base, left_upd;
   logic                        newly, stop_abort, stop_done, push;
   result_type                  push_data;

   always_comb begin
      diff     = $signed({s1_value_ff[VALUE_WIDTH-1], s1_value_ff})
               - $signed({ref_data_ff[VALUE_WIDTH-1], ref_data_ff});
      diff_abs = diff[VALUE_WIDTH] ? (~diff + 1'b1) : diff;
      mag      = CMP_W'(diff_abs[VALUE_WIDTH-1:0]);
      if (approx_mode_ff)
         varies = mag > CMP_W'(tolerance_ff);
      else
         varies = s1_value_ff != ref_data_ff;
   end

   always_comb begin
      flags_base = s1_start_ff ? '0 : flags_ff;
      left_base  = s1_start_ff ? eff_cols : left_ff;
      col_bit    = MAX_COLUMNS'(1) << s1_pos_ff;
      newly      = s1_valid_ff && !stopped_ff && !s1_first_ff && varies
                && !flags_base[s1_pos_ff];
      flags_upd  = newly ? (flags_base | col_bit) : flags_base;
      left_upd   = (newly && (left_base != '0)) ? (left_base - COUNT_W'(1)) : left_base;
      stop_abort = newly && (left_upd < abort_floor_ff);
      stop_done  = newly && !stop_abort && (left_upd == '0);
      push       = s1_valid_ff && !stopped_ff && (stop_abort || stop_done || s1_last_ff);
      push_data.verdict = stop_abort ? VERDICT_ABORT : VERDICT_DONE;
      push_data.mask    = MASK_W'(flags_upd);
      push_data.count   = left_upd;
   end

   // per-matrix state; the last element always restarts it
   always_comb begin
      flags_in   = flags_ff;
      left_in    = left_ff;
      stopped_in = stopped_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            flags_in   = '0;
            left_in    = eff_cols;
            stopped_in = 1'b0;
         end else if (!stopped_ff) begin
            flags_in   = flags_upd;
            left_in    = left_upd;
            stopped_in = stop_abort || stop_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         left_ff    <= MAX_CNT;
         stopped_ff <= 1'b0;
      end else begin
         flags_ff   <= flags_in;
         left_ff    <= left_in;
         stopped_ff <= stopped_in;
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   result_type         queue_ff [FIFO_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic               pop;
   result_type         head;

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (q_count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign q_count_in = q_count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push)
         queue_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         q_count_ff <= q_count_in;
      end
   end

   assign rsp_verdict        = head.verdict;
   assign rsp_variable_mask  = head.mask;
   assign rsp_constant_count = head.count;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_full_no_inflight: assert property (@(posedge clock) disable iff (reset)
      (q_count_ff == QCNT_W'(FIFO_DEPTH)) |-> !s1_valid_ff)
      else $error("element in flight with full result queue");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && stopped_ff) |-> !push)
      else $error("result produced after a stop");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= MAX_CNT)
      else $error("constant count above column limit");

endmodule
